[rtl/core/sbss_pkg.sv]
// Package: payload structs, sequencer states and constants of the split scanner.
`timescale 1ns / 1ps
`default_nettype none
package sbss_pkg;

    localparam int MAX_SAMPLES   = 65536;
    localparam int MAX_VARIABLES = 1024;

    localparam logic [1:0] KIND_TOTAL   = 2'd0;
    localparam logic [1:0] KIND_SCAN    = 2'd1;
    localparam logic [1:0] KIND_REPORT  = 2'd2;
    localparam logic [1:0] KIND_IGNORED = 2'd3;

    localparam logic [1:0] CFG_USED_SAMPLE_COUNT = 2'd0;
    localparam logic [1:0] CFG_MIN_NODE_SIZE     = 2'd1;
    localparam logic [1:0] CFG_MIN_NODE_WEIGHT   = 2'd2;
    localparam logic [1:0] CFG_MIN_GAIN          = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        weight;
        logic signed [31:0] target;
        logic signed [31:0] feature_value;
        logic [9:0]         variable_index;
        logic               last_of_variable;
    } t_in;

    typedef struct packed {
        logic               split_found;
        logic [9:0]         best_variable;
        logic signed [31:0] threshold;
        logic signed [31:0] left_value;
        logic signed [31:0] right_value;
        logic [47:0]        gain;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_DISP, S_SCAN, S_SQ, S_DIVINIT, S_DIV, S_POST, S_MUL, S_UPD, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        J_BASE, J_LEFT, J_RIGHT, J_LMEAN, J_RMEAN, J_GAIN, J_TMEAN
    } t_job;

    typedef enum logic [1:0] {
        SRC_TOTAL, SRC_LEFT, SRC_RIGHT
    } t_src;

endpackage
`default_nettype wire

[rtl/core/stump_best_split_scan.sv]
// Top level: exact greedy regression stump split search over a streamed, sorted sample set.
`timescale 1ns / 1ps
`default_nettype none
// One transaction is taken at a time; o_stall stays high until it is done. A total-sum
// transaction multiplies and accumulates. A scan transaction computes, at each boundary, two
// score terms (32x32 partial products, then the shared restoring divider), plus the two means
// when the boundary becomes the new best, plus the base score on the first scan transaction
// of a round. A report transaction holds its result until taken; it clears all scan state,
// keeping the configuration registers. All of these steps run on the one divider and the one
// multiplier.
module stump_best_split_scan (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire sbss_pkg::t_in   i_data,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output sbss_pkg::t_out       o_data,
    input  wire logic            i_cfg_valid,
    output logic                 o_cfg_ready,
    input  wire logic [1:0]      i_cfg_index,
    input  wire logic [47:0]     i_cfg_data
);

    sbss_pkg::t_state r_state, n_state;
    sbss_pkg::t_in    r_in;
    sbss_pkg::t_out   r_out;
    sbss_pkg::t_job   r_job;

    logic [16:0] r_n, r_mns;
    logic [47:0] r_mnw, r_min_gain;

    logic [47:0]        r_tw, r_lw;
    logic signed [63:0] r_twt, r_lwt;
    logic [16:0]        r_k;
    logic               r_held_valid;
    logic signed [31:0] r_held;
    logic [63:0]        r_best;
    logic               r_started;
    logic               r_found;
    logic [9:0]         r_bvar;
    logic signed [31:0] r_bthr, r_bleft;

    logic [63:0]        r_opa;
    logic [47:0]        r_den;
    logic               r_neg;
    logic [63:0]        r_hi, r_lo;
    logic [47:0]        r_rem;
    logic [5:0]         r_cnt;
    logic [63:0]        r_sl;
    logic [63:0]        r_cscore;
    logic signed [31:0] r_cthr, r_cleft;
    logic signed [41:0] r_wt;

    logic               c_start, c_mean, c_take;
    sbss_pkg::t_job     c_job;
    sbss_pkg::t_src     c_src;
    logic signed [63:0] c_s;
    logic [47:0]        c_w;
    logic [63:0]        c_mag;

    logic [47:0]        rw;
    logic signed [63:0] rwy;
    logic signed [64:0] rwy_full;
    logic [64:0]        score_full;
    logic [63:0]        score;
    logic signed [32:0] mid_sum;
    logic signed [31:0] mid;
    logic [16:0]        n_minus_k;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  mul_p;
    logic [127:0] sq_add;
    logic [48:0]  div_sh;
    logic [48:0]  div_diff;
    logic         div_bit;
    logic [31:0]  mag_y;
    logic [63:0]  wt_round;
    logic signed [31:0] mean_res;

    logic signed [64:0] add_t, add_l;
    logic signed [63:0] sat_t, sat_l;
    logic [48:0]        addw_t, addw_l;
    logic [64:0]        base_sum;
    logic [63:0]        gain_diff;

    assign rw        = (r_tw > r_lw) ? (r_tw - r_lw) : 48'd0;
    assign rwy_full  = {r_twt[63], r_twt} - {r_lwt[63], r_lwt};
    assign rwy       = (rwy_full[64] != rwy_full[63])
                       ? (rwy_full[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}})
                       : rwy_full[63:0];
    assign score_full = {1'b0, r_sl} + {1'b0, r_lo};
    assign score      = score_full[64] ? {64{1'b1}} : score_full[63:0];
    assign mid_sum    = {r_held[31], r_held} + {r_in.feature_value[31], r_in.feature_value};
    assign mid        = mid_sum[32:1];
    assign n_minus_k  = r_n - r_k;

    assign c_take = (score > r_best) && (r_k >= r_mns) && (r_k <= r_n)
                    && (n_minus_k >= r_mns) && (r_lw != 48'd0) && (rw != 48'd0)
                    && (r_lw >= r_mnw) && (rw >= r_mnw) && (mid != r_held);

    always_comb begin
        c_start = 1'b0;
        c_job   = sbss_pkg::J_LEFT;
        c_src   = sbss_pkg::SRC_TOTAL;
        unique case (r_state)
            sbss_pkg::S_DISP: begin
                if (r_in.kind == sbss_pkg::KIND_SCAN && !r_started) begin
                    c_start = 1'b1;
                    c_job   = sbss_pkg::J_BASE;
                end else if (r_in.kind == sbss_pkg::KIND_REPORT && r_tw != 48'd0) begin
                    c_start = 1'b1;
                    c_job   = r_found ? sbss_pkg::J_GAIN : sbss_pkg::J_TMEAN;
                end
            end
            sbss_pkg::S_SCAN: begin
                if (r_held_valid) begin
                    c_start = 1'b1;
                    c_job   = sbss_pkg::J_LEFT;
                    c_src   = sbss_pkg::SRC_LEFT;
                end
            end
            sbss_pkg::S_POST: begin
                unique case (r_job)
                    sbss_pkg::J_LEFT: begin
                        c_start = 1'b1;
                        c_job   = sbss_pkg::J_RIGHT;
                        c_src   = sbss_pkg::SRC_RIGHT;
                    end
                    sbss_pkg::J_RIGHT: begin
                        c_start = c_take;
                        c_job   = sbss_pkg::J_LMEAN;
                        c_src   = sbss_pkg::SRC_LEFT;
                    end
                    sbss_pkg::J_LMEAN: begin
                        c_start = 1'b1;
                        c_job   = sbss_pkg::J_RMEAN;
                        c_src   = sbss_pkg::SRC_RIGHT;
                    end
                    default: c_start = 1'b0;
                endcase
            end
            default: c_start = 1'b0;
        endcase
    end

    assign c_mean = (c_job == sbss_pkg::J_LMEAN) || (c_job == sbss_pkg::J_RMEAN)
                    || (c_job == sbss_pkg::J_TMEAN);

    always_comb begin
        unique case (c_src)
            sbss_pkg::SRC_LEFT:  begin c_s = r_lwt; c_w = r_lw; end
            sbss_pkg::SRC_RIGHT: begin c_s = rwy;   c_w = rw;   end
            default:             begin c_s = r_twt; c_w = r_tw; end
        endcase
    end
    assign c_mag = c_s[63] ? (64'd0 - c_s) : c_s;

    assign mag_y = r_in.target[31] ? (32'd0 - r_in.target) : r_in.target;
    always_comb begin
        if (r_state == sbss_pkg::S_MUL) begin
            mul_a = r_in.weight;
            mul_b = mag_y;
        end else begin
            mul_a = r_cnt[1] ? r_opa[63:32] : r_opa[31:0];
            mul_b = r_cnt[0] ? r_opa[63:32] : r_opa[31:0];
        end
    end
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    always_comb begin
        unique case (r_cnt[1:0])
            2'd0:    sq_add = {64'd0, mul_p};
            2'd3:    sq_add = {mul_p, 64'd0};
            default: sq_add = {32'd0, mul_p, 32'd0};
        endcase
    end

    assign div_sh   = {r_rem, r_lo[63]};
    assign div_bit  = div_sh >= {1'b0, r_den};
    assign div_diff = div_sh - {1'b0, r_den};
    assign wt_round = (mul_p + 64'hFF_FFFF) >> 24;

    always_comb begin
        if (r_neg) begin
            mean_res = (r_lo >= 64'h8000_0000) ? 32'sh8000_0000 : (32'd0 - r_lo[31:0]);
        end else begin
            mean_res = (r_lo > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : r_lo[31:0];
        end
    end

    assign add_t  = {r_twt[63], r_twt} + {{23{r_wt[41]}}, r_wt};
    assign add_l  = {r_lwt[63], r_lwt} + {{23{r_wt[41]}}, r_wt};
    assign sat_t  = (add_t[64] != add_t[63])
                    ? (add_t[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : add_t[63:0];
    assign sat_l  = (add_l[64] != add_l[63])
                    ? (add_l[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : add_l[63:0];
    assign addw_t = {1'b0, r_tw} + {17'd0, r_in.weight};
    assign addw_l = {1'b0, r_lw} + {17'd0, r_in.weight};
    assign base_sum  = {1'b0, r_lo} + {17'd0, r_min_gain};
    assign gain_diff = (r_best > r_lo) ? (r_best - r_lo) : 64'd0;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sbss_pkg::S_IDLE: if (i_valid) n_state = sbss_pkg::S_DISP;
            sbss_pkg::S_DISP: begin
                if (c_start) begin
                    n_state = c_mean ? sbss_pkg::S_DIVINIT : sbss_pkg::S_SQ;
                end else begin
                    unique case (r_in.kind)
                        sbss_pkg::KIND_TOTAL:  n_state = sbss_pkg::S_MUL;
                        sbss_pkg::KIND_SCAN:   n_state = sbss_pkg::S_SCAN;
                        sbss_pkg::KIND_REPORT: n_state = sbss_pkg::S_OUT;
                        default:               n_state = sbss_pkg::S_IDLE;
                    endcase
                end
            end
            sbss_pkg::S_SCAN: n_state = c_start ? sbss_pkg::S_SQ : sbss_pkg::S_MUL;
            sbss_pkg::S_SQ:   if (r_cnt[1:0] == 2'd3) n_state = sbss_pkg::S_DIVINIT;
            sbss_pkg::S_DIVINIT: begin
                if (r_den == 48'd0 || r_hi >= {16'd0, r_den}) n_state = sbss_pkg::S_POST;
                else n_state = sbss_pkg::S_DIV;
            end
            sbss_pkg::S_DIV:  if (r_cnt == 6'd63) n_state = sbss_pkg::S_POST;
            sbss_pkg::S_POST: begin
                if (c_start) begin
                    n_state = c_mean ? sbss_pkg::S_DIVINIT : sbss_pkg::S_SQ;
                end else begin
                    unique case (r_job)
                        sbss_pkg::J_BASE:  n_state = sbss_pkg::S_SCAN;
                        sbss_pkg::J_GAIN,
                        sbss_pkg::J_TMEAN: n_state = sbss_pkg::S_OUT;
                        default:           n_state = sbss_pkg::S_MUL;
                    endcase
                end
            end
            sbss_pkg::S_MUL: n_state = sbss_pkg::S_UPD;
            sbss_pkg::S_UPD: n_state = sbss_pkg::S_IDLE;
            sbss_pkg::S_OUT: if (!i_stall) n_state = sbss_pkg::S_IDLE;
            default:         n_state = sbss_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != sbss_pkg::S_IDLE);
        o_valid     = (r_state == sbss_pkg::S_OUT);
        o_data      = r_out;
        o_cfg_ready = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= sbss_pkg::S_IDLE;
            r_n          <= 17'd2;
            r_mns        <= 17'd1;
            r_mnw        <= 48'd0;
            r_min_gain   <= 48'd0;
            r_tw         <= 48'd0;
            r_lw         <= 48'd0;
            r_twt        <= 64'sd0;
            r_lwt        <= 64'sd0;
            r_k          <= 17'd0;
            r_held_valid <= 1'b0;
            r_held       <= 32'sd0;
            r_best       <= 64'd0;
            r_started    <= 1'b0;
            r_found      <= 1'b0;
            r_bvar       <= 10'd0;
            r_bthr       <= 32'sd0;
            r_bleft      <= 32'sd0;
            r_out        <= '0;
            r_job        <= sbss_pkg::J_BASE;
            r_cnt        <= 6'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    sbss_pkg::CFG_USED_SAMPLE_COUNT: r_n        <= i_cfg_data[16:0];
                    sbss_pkg::CFG_MIN_NODE_SIZE:     r_mns      <= i_cfg_data[16:0];
                    sbss_pkg::CFG_MIN_NODE_WEIGHT:   r_mnw      <= i_cfg_data;
                    sbss_pkg::CFG_MIN_GAIN:          r_min_gain <= i_cfg_data;
                    default:                         r_n        <= r_n;
                endcase
            end
            if (r_state == sbss_pkg::S_IDLE && i_valid) r_in <= i_data;

            if (c_start) begin
                r_job <= c_job;
                r_den <= c_w;
                r_neg <= c_s[63];
                r_opa <= c_mag;
                r_cnt <= 6'd0;
                if (c_mean) begin
                    r_hi <= {40'd0, c_mag[63:40]};
                    r_lo <= {c_mag[39:0], 24'd0};
                end else begin
                    r_hi <= 64'd0;
                    r_lo <= 64'd0;
                end
            end

            unique case (r_state)
                sbss_pkg::S_DISP: begin
                    if (r_in.kind == sbss_pkg::KIND_REPORT && r_tw == 48'd0) r_out <= '0;
                end
                sbss_pkg::S_SQ: begin
                    {r_hi, r_lo} <= {r_hi, r_lo} + sq_add;
                    r_cnt        <= r_cnt + 6'd1;
                end
                sbss_pkg::S_DIVINIT: begin
                    r_cnt <= 6'd0;
                    r_rem <= r_hi[47:0];
                    if (r_den == 48'd0) r_lo <= 64'd0;
                    else if (r_hi >= {16'd0, r_den}) r_lo <= {64{1'b1}};
                end
                sbss_pkg::S_DIV: begin
                    r_cnt <= r_cnt + 6'd1;
                    r_rem <= div_bit ? div_diff[47:0] : div_sh[47:0];
                    r_lo  <= {r_lo[62:0], div_bit};
                end
                sbss_pkg::S_POST: begin
                    unique case (r_job)
                        sbss_pkg::J_BASE: begin
                            r_best    <= base_sum[64] ? {64{1'b1}} : base_sum[63:0];
                            r_started <= 1'b1;
                        end
                        sbss_pkg::J_LEFT:  r_sl <= r_lo;
                        sbss_pkg::J_RIGHT: begin
                            r_cscore <= score;
                            r_cthr   <= mid;
                        end
                        sbss_pkg::J_LMEAN: r_cleft <= mean_res;
                        sbss_pkg::J_RMEAN: begin
                            r_best  <= r_cscore;
                            r_found <= 1'b1;
                            r_bvar  <= r_in.variable_index;
                            r_bthr  <= r_cthr;
                            r_bleft <= r_cleft;
                            r_out.right_value <= mean_res;
                        end
                        sbss_pkg::J_GAIN: begin
                            r_out.split_found   <= 1'b1;
                            r_out.best_variable <= r_bvar;
                            r_out.threshold     <= r_bthr;
                            r_out.left_value    <= r_bleft;
                            r_out.gain <= (gain_diff > 64'hFFFF_FFFF_FFFF)
                                          ? 48'hFFFF_FFFF_FFFF : gain_diff[47:0];
                        end
                        default: begin
                            r_out <= '{split_found: 1'b0, best_variable: 10'd0,
                                       threshold: 32'sd0, left_value: mean_res,
                                       right_value: 32'sd0, gain: 48'd0};
                        end
                    endcase
                end
                sbss_pkg::S_MUL: begin
                    r_wt <= r_in.target[31] ? (42'sd0 - {1'b0, wt_round[40:0]})
                                            : {2'b0, mul_p[63:24]};
                end
                sbss_pkg::S_UPD: begin
                    if (r_in.kind == sbss_pkg::KIND_TOTAL) begin
                        r_tw  <= addw_t[48] ? 48'hFFFF_FFFF_FFFF : addw_t[47:0];
                        r_twt <= sat_t;
                    end else if (r_in.last_of_variable) begin
                        r_lw         <= 48'd0;
                        r_lwt        <= 64'sd0;
                        r_k          <= 17'd0;
                        r_held_valid <= 1'b0;
                        r_held       <= 32'sd0;
                    end else begin
                        r_lw  <= addw_l[48] ? 48'hFFFF_FFFF_FFFF : addw_l[47:0];
                        r_lwt <= sat_l;
                        if (r_k < 17'(sbss_pkg::MAX_SAMPLES)) r_k <= r_k + 17'd1;
                        r_held       <= r_in.feature_value;
                        r_held_valid <= 1'b1;
                    end
                end
                default: ;
            endcase

            if (r_state != sbss_pkg::S_OUT && n_state == sbss_pkg::S_OUT) begin
                r_tw         <= 48'd0;
                r_lw         <= 48'd0;
                r_twt        <= 64'sd0;
                r_lwt        <= 64'sd0;
                r_k          <= 17'd0;
                r_held_valid <= 1'b0;
                r_held       <= 32'sd0;
                r_best       <= 64'd0;
                r_started    <= 1'b0;
                r_found      <= 1'b0;
                r_bvar       <= 10'd0;
                r_bthr       <= 32'sd0;
                r_bleft      <= 32'sd0;
            end
        end
    end

`ifndef SYNTHESIS
    a_div_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sbss_pkg::S_DIV) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("accepted a transaction without going busy");
    a_found_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> r_started)
        else $error("split recorded before score start");
    a_held_needs_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held_valid |-> (r_k != 17'd0))
        else $error("held sample without left samples");
`endif

endmodule
`default_nettype wire

[tb/tb_stump_best_split_scan.sv]
// Testbench: self-checking stimulus, split-search predictor and result checker for the top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_stump_best_split_scan;

    localparam int  SETTLE_CYCLES = 400;
    localparam int  CYCLE_LIMIT   = 3000000;
    localparam int  ITEM_TARGET   = 1700;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_valid;
    logic           o_stall;
    sbss_pkg::t_in  i_data;
    logic           o_valid;
    logic           i_stall;
    sbss_pkg::t_out o_data;
    logic           i_cfg_valid;
    logic           o_cfg_ready;
    logic [1:0]     i_cfg_index;
    logic [47:0]    i_cfg_data;

    stump_best_split_scan DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // split-search mirror state
    logic [16:0]        n_used, min_size;
    logic [47:0]        min_weight, min_gain_q;
    logic [47:0]        sum_w, left_w;
    logic signed [63:0] sum_wy, left_wy;
    logic [16:0]        left_count;
    logic               prev_ok;
    logic signed [31:0] prev_fx;
    logic [63:0]        best_q;
    logic               started;
    logic               found;
    logic [9:0]         found_var;
    logic signed [31:0] found_thr, found_lv, found_rv;

    sbss_pkg::t_out split_reports[$];
    int     mismatches;
    int     items_sent;
    int     cycles;
    int     gap_max;
    int     stall_max;
    int     stall_cnt;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_stump_best_split_scan: FAIL");
            $finish;
        end
    end

    function automatic logic [63:0] sq_over_w(logic signed [63:0] s, logic [47:0] w);
        logic [63:0]  a;
        logic [127:0] q;
        if (w == 0) return 64'd0;
        a = (s < 0) ? 64'(-s) : 64'(s);
        q = ({64'd0, a} * {64'd0, a}) / {80'd0, w};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic signed [31:0] mean_of(logic signed [63:0] s, logic [47:0] w);
        logic [63:0]  a;
        logic [127:0] q;
        if (w == 0) return 32'sd0;
        a = (s < 0) ? 64'(-s) : 64'(s);
        q = ({64'd0, a} << 24) / {80'd0, w};
        if (q[127:64] != 0) q = {64'd0, {64{1'b1}}};
        if (s < 0) return (q >= 128'h8000_0000) ? 32'sh8000_0000 : -$signed(q[31:0]);
        return (q > 128'h7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
    endfunction

    function automatic logic signed [63:0] wy_of(logic [31:0] w, logic signed [31:0] y);
        logic signed [63:0] y64;
        logic [63:0]        mag;
        y64 = y;
        mag = {32'd0, w} * ((y64 < 0) ? 64'(-y64) : 64'(y64));
        if (y64 < 0) return -$signed((mag + 64'hFF_FFFF) >> 24);
        return $signed(mag >> 24);
    endfunction

    function automatic logic signed [63:0] sat_s64(logic signed [64:0] r);
        if (r > 65'(S64_MAX)) return S64_MAX;
        if (r < 65'(S64_MIN)) return S64_MIN;
        return r[63:0];
    endfunction

    function automatic logic [47:0] add_w48(logic [47:0] a, logic [31:0] b);
        logic [48:0] r;
        r = {1'b0, a} + {17'd0, b};
        return r[48] ? MAX48 : r[47:0];
    endfunction

    function automatic logic [63:0] add_u64(logic [63:0] a, logic [63:0] b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[64] ? '1 : r[63:0];
    endfunction

    function automatic void clear_round();
        sum_w = 0; left_w = 0; sum_wy = 0; left_wy = 0; left_count = 0;
        prev_ok = 0; prev_fx = 0; best_q = 0; started = 0;
        found = 0; found_var = 0; found_thr = 0; found_lv = 0; found_rv = 0;
    endfunction

    function automatic void predict_split(sbss_pkg::t_in it);
        logic [47:0]        rw;
        logic signed [63:0] rwy, left_in;
        logic [63:0]        sc, base, g;
        logic signed [64:0] r;
        logic signed [32:0] mid;
        sbss_pkg::t_out     res;
        case (it.kind)
            sbss_pkg::KIND_TOTAL: begin
                sum_w = add_w48(sum_w, it.weight);
                r = sum_wy;
                left_in = wy_of(it.weight, it.target);
                sum_wy = sat_s64(r + left_in);
            end
            sbss_pkg::KIND_SCAN: begin
                if (!started) begin
                    best_q  = add_u64(sq_over_w(sum_wy, sum_w), {16'd0, min_gain_q});
                    started = 1;
                end
                if (prev_ok) begin
                    rw  = (sum_w > left_w) ? sum_w - left_w : 48'd0;
                    r   = sum_wy;
                    rwy = sat_s64(r - left_wy);
                    sc  = add_u64(sq_over_w(left_wy, left_w), sq_over_w(rwy, rw));
                    if (sc > best_q && left_count >= min_size && left_count <= n_used
                        && n_used - left_count >= min_size && left_w != 0 && rw != 0
                        && left_w >= min_weight && rw >= min_weight) begin
                        mid = ({prev_fx[31], prev_fx} + {it.feature_value[31], it.feature_value})
                              >>> 1;
                        if (mid[31:0] != prev_fx) begin
                            best_q    = sc;
                            found     = 1;
                            found_var = it.variable_index;
                            found_thr = mid[31:0];
                            found_lv  = mean_of(left_wy, left_w);
                            found_rv  = mean_of(rwy, rw);
                        end
                    end
                end
                if (it.last_of_variable) begin
                    left_w = 0; left_wy = 0; left_count = 0; prev_ok = 0; prev_fx = 0;
                end else begin
                    left_w = add_w48(left_w, it.weight);
                    r = left_wy;
                    left_in = wy_of(it.weight, it.target);
                    left_wy = sat_s64(r + left_in);
                    if (left_count < sbss_pkg::MAX_SAMPLES) left_count = left_count + 1;
                    prev_fx = it.feature_value;
                    prev_ok = 1;
                end
            end
            sbss_pkg::KIND_REPORT: begin
                res = '0;
                if (sum_w != 0) begin
                    if (found) begin
                        base = sq_over_w(sum_wy, sum_w);
                        g    = (best_q > base) ? best_q - base : 64'd0;
                        res.split_found   = 1;
                        res.best_variable = found_var;
                        res.threshold     = found_thr;
                        res.left_value    = found_lv;
                        res.right_value   = found_rv;
                        res.gain          = (g > {16'd0, MAX48}) ? MAX48 : g[47:0];
                    end else begin
                        res.left_value = mean_of(sum_wy, sum_w);
                    end
                end
                split_reports.push_back(res);
                clear_round();
            end
            default: ;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall   <= 1'b0;
            stall_cnt <= 0;
        end else begin
            if (o_valid && !i_stall) begin
                if (split_reports.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected transaction %p", o_data);
                end else begin
                    if (o_data.split_found !== split_reports[0].split_found
                        || o_data.best_variable !== split_reports[0].best_variable
                        || o_data.threshold !== split_reports[0].threshold
                        || o_data.left_value !== split_reports[0].left_value
                        || o_data.right_value !== split_reports[0].right_value
                        || o_data.gain !== split_reports[0].gain) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: expected %p actual %p",
                                     split_reports[0], o_data);
                    end
                    void'(split_reports.pop_front());
                end
                stall_cnt <= $urandom_range(0, stall_max);
                i_stall   <= 1'b0;
            end else if (stall_cnt > 0) begin
                i_stall   <= 1'b1;
                stall_cnt <= stall_cnt - 1;
            end else begin
                i_stall   <= 1'b0;
            end
        end
    end

    task automatic send_item(input sbss_pkg::t_in it);
        int gap;
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_split(it);
        if (it.kind != sbss_pkg::KIND_IGNORED) items_sent++;
    endtask

    task automatic idle_line();
        i_valid <= 1'b0;
        wait (split_reports.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [47:0] value);
        idle_line();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            sbss_pkg::CFG_USED_SAMPLE_COUNT: n_used     = value[16:0];
            sbss_pkg::CFG_MIN_NODE_SIZE:     min_size   = value[16:0];
            sbss_pkg::CFG_MIN_NODE_WEIGHT:   min_weight = value;
            sbss_pkg::CFG_MIN_GAIN:          min_gain_q = value;
            default: ;
        endcase
    endtask

    function automatic sbss_pkg::t_in make_item(logic [1:0] k, logic [31:0] w, logic [31:0] y,
                                                logic [31:0] f, logic [9:0] v, logic l);
        sbss_pkg::t_in it;
        it.kind = k; it.weight = w; it.target = y;
        it.feature_value = f; it.variable_index = v; it.last_of_variable = l;
        return it;
    endfunction

    task automatic random_round(input bit noisy);
        int                 n, len, nv, spread;
        logic [31:0]        ws[$], ys[$];
        logic signed [31:0] fs[$];
        logic [9:0]         v;
        logic [31:0]        tmp;
        int                 j;
        n = (n_used <= 10) ? int'(n_used) : $urandom_range(2, 10);
        ws.delete(); ys.delete();
        for (int i = 0; i < n; i++) begin
            ws.push_back(($urandom_range(0, 9) == 0) ? $urandom
                                                     : $urandom_range(0, 32'h0400_0000));
            ys.push_back(($urandom_range(0, 3) == 0) ? $urandom
                                                     : $signed($urandom_range(0, 32'h0A00_0000))
                                                       - 32'sh0500_0000);
        end
        for (int i = 0; i < n; i++)
            if (!(noisy && $urandom_range(0, 3) == 0))
                send_item(make_item(sbss_pkg::KIND_TOTAL, ws[i], ys[i], $urandom,
                                    10'($urandom), 1'($urandom)));
        nv = $urandom_range(1, 3);
        for (int q = 0; q < nv; q++) begin
            v      = 10'($urandom);
            spread = $urandom_range(0, 2);
            len    = (noisy && $urandom_range(0, 1)) ? $urandom_range(1, n + 1) : n;
            fs.delete();
            for (int i = 0; i < len; i++)
                fs.push_back(spread == 0 ? $signed($urandom_range(0, 3))
                           : spread == 1 ? $signed($urandom_range(0, 200)) - 100
                           : $signed($urandom));
            if (!(noisy && $urandom_range(0, 2) == 0)) fs.sort();
            for (int i = 0; i < len; i++) begin
                j = i % n;
                if (noisy && $urandom_range(0, 7) == 0)
                    send_item(make_item(sbss_pkg::KIND_IGNORED, $urandom, $urandom, $urandom,
                                        10'($urandom), 1'($urandom)));
                send_item(make_item(sbss_pkg::KIND_SCAN, ws[j], ys[j], fs[i], v, i == len - 1));
            end
            if (noisy && $urandom_range(0, 3) == 0)
                send_item(make_item(sbss_pkg::KIND_TOTAL, $urandom, $urandom, $urandom,
                                    10'($urandom), 1'b0));
        end
        tmp = $urandom;
        send_item(make_item(sbss_pkg::KIND_REPORT, tmp, $urandom, $urandom,
                            10'($urandom), tmp[0]));
    endtask

    task automatic test_defaults();
        send_item(make_item(sbss_pkg::KIND_REPORT, '0, '0, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_IGNORED, '1, '1, '1, '1, 1'b1));
        send_item(make_item(sbss_pkg::KIND_TOTAL, 32'hFFFF_FFFF, 32'h8000_0000, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_TOTAL, 32'hFFFF_FFFF, 32'h7FFF_FFFF, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_TOTAL, '0, 32'h8000_0000, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_REPORT, '0, '0, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_TOTAL, 32'h0100_0000, 32'h0200_0000, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_TOTAL, 32'h0100_0000, 32'hFE00_0000, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_SCAN, 32'h0100_0000, 32'h0200_0000, 32'h8000_0000,
                            10'd1023, 1'b0));
        send_item(make_item(sbss_pkg::KIND_SCAN, 32'h0100_0000, 32'hFE00_0000, 32'h7FFF_FFFF,
                            10'd1023, 1'b1));
        send_item(make_item(sbss_pkg::KIND_SCAN, 32'h0100_0000, 32'h0200_0000, 32'd5,
                            10'd0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_SCAN, 32'h0100_0000, 32'hFE00_0000, 32'd6,
                            10'd0, 1'b1));
        send_item(make_item(sbss_pkg::KIND_REPORT, '0, '0, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_TOTAL, 32'h0080_0000, 32'h0300_0000, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_SCAN, 32'h0080_0000, 32'h0300_0000, 32'd7,
                            10'd9, 1'b0));
        send_item(make_item(sbss_pkg::KIND_TOTAL, 32'h0080_0000, 32'hFF00_0000, '0, '0, 1'b0));
        send_item(make_item(sbss_pkg::KIND_SCAN, 32'h0080_0000, 32'hFF00_0000, 32'd7,
                            10'd9, 1'b1));
        send_item(make_item(sbss_pkg::KIND_REPORT, '0, '0, '0, '0, 1'b0));
    endtask

    task automatic test_register_extremes();
        write_reg(sbss_pkg::CFG_USED_SAMPLE_COUNT, 48'd65536);
        write_reg(sbss_pkg::CFG_MIN_NODE_SIZE, 48'd65536);
        write_reg(sbss_pkg::CFG_MIN_NODE_WEIGHT, MAX48);
        write_reg(sbss_pkg::CFG_MIN_GAIN, MAX48);
        repeat (3) random_round(1'b0);
        write_reg(sbss_pkg::CFG_USED_SAMPLE_COUNT, 48'd2);
        write_reg(sbss_pkg::CFG_MIN_NODE_SIZE, 48'd1);
        write_reg(sbss_pkg::CFG_MIN_NODE_WEIGHT, 48'd0);
        write_reg(sbss_pkg::CFG_MIN_GAIN, 48'd0);
        repeat (3) random_round(1'b0);
    endtask

    task automatic test_random_rounds();
        int rounds;
        rounds = 0;
        while (items_sent < ITEM_TARGET) begin
            if (rounds % 12 == 0) begin
                write_reg(sbss_pkg::CFG_USED_SAMPLE_COUNT, 48'($urandom_range(2, 8)));
                write_reg(sbss_pkg::CFG_MIN_NODE_SIZE, 48'($urandom_range(1, 3)));
                write_reg(sbss_pkg::CFG_MIN_NODE_WEIGHT, $urandom_range(0, 1) ? 48'd0
                                               : 48'($urandom_range(0, 32'h0200_0000)));
                write_reg(sbss_pkg::CFG_MIN_GAIN, $urandom_range(0, 1) ? 48'd0
                                        : 48'({$urandom, $urandom} & 64'h0000_3FFF_FFFF));
            end
            if (rounds % 7 == 0) begin
                gap_max   = $urandom_range(0, 1) ? 8 : 0;
                stall_max = $urandom_range(0, 1) ? 8 : 0;
            end
            random_round($urandom_range(0, 4) == 0);
            rounds++;
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_data      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= sbss_pkg::CFG_USED_SAMPLE_COUNT;
        i_cfg_data  <= '0;
        cycles      = 0;
        mismatches  = 0;
        items_sent  = 0;
        gap_max     = 8;
        stall_max   = 8;
        n_used = 17'd2; min_size = 17'd1; min_weight = 0; min_gain_q = 0;
        clear_round();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_defaults();
        test_register_extremes();
        test_random_rounds();

        idle_line();
        if (mismatches == 0 && split_reports.size() == 0) begin
            $display("tb_stump_best_split_scan: PASS");
        end else begin
            $display("tb_stump_best_split_scan: FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
